// ===== sv/y2r_pkg.sv =====
`timescale 1ns / 1ps

package y2r_pkg;

  // field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 8;
  localparam int COEF_W     = 18;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = COEF_W + 1 + DIFF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DEPTH_W    = 5;

  // sample offsets
  localparam int BYTE_DEPTH    = 8;
  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;
  localparam int CHAN_MAX      = (1 << CHAN_W) - 1;

  typedef enum logic [1:0] {
    MAT_BT601   = 2'd0,
    MAT_BT709   = 2'd1,
    MAT_BT2020  = 2'd2,
    MAT_UNSPEC  = 2'd3
  } matrix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_SELECT    = 2'd0,
    REG_FULL_RANGE       = 2'd1,
    REG_TWO_BYTE_SAMPLES = 2'd2,
    REG_BIT_DEPTH        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    matrix_t             matrix_select;
    logic                full_range;
    logic                two_byte_samples;
    logic [DEPTH_W-1:0]  bit_depth;
  } cfg_t;

  // q16 coefficients, all magnitudes
  typedef struct packed {
    logic [COEF_W-1:0] ys;
    logic [COEF_W-1:0] crv;
    logic [COEF_W-1:0] cgu;
    logic [COEF_W-1:0] cgv;
    logic [COEF_W-1:0] cbu;
  } coef_t;

  // coefficient set per range and matrix, range scaling folded in
  function automatic coef_t coef_lookup(input logic full, input matrix_t m);
    coef_t c;
    if (!full) begin
      case (m)
        MAT_BT601:  c = '{18'd76309, 18'd104597, 18'd25675, 18'd53279, 18'd132201};
        MAT_BT2020: c = '{18'd76309, 18'd110014, 18'd12277, 18'd42626, 18'd140363};
        default:    c = '{18'd76309, 18'd117489, 18'd13975, 18'd34925, 18'd138438};
      endcase
    end else begin
      case (m)
        MAT_BT601:  c = '{18'd65536, 18'd91881, 18'd22553, 18'd46802, 18'd116130};
        MAT_BT2020: c = '{18'd65536, 18'd96639, 18'd10784, 18'd37444, 18'd123299};
        default:    c = '{18'd65536, 18'd103206, 18'd12276, 18'd30679, 18'd121609};
      endcase
    end
    return c;
  endfunction

endpackage

// ===== sv/y2r_yuv_if.sv =====
`timescale 1ns / 1ps

interface y2r_yuv_if;
  import y2r_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_sample;
  logic [SAMPLE_W-1:0] blue_diff_sample;
  logic [SAMPLE_W-1:0] red_diff_sample;

  modport source (output valid, luma_sample, blue_diff_sample, red_diff_sample, input ready);
  modport sink   (input valid, luma_sample, blue_diff_sample, red_diff_sample, output ready);
endinterface

// ===== sv/y2r_rgb_if.sv =====
`timescale 1ns / 1ps

interface y2r_rgb_if;
  import y2r_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== sv/y2r_pipe.sv =====
`timescale 1ns / 1ps

module y2r_pipe (
  input  logic          clk,
  input  logic          rst,
  input  y2r_pkg::cfg_t cfg,
  y2r_yuv_if.sink       yuv,
  y2r_rgb_if.source     rgb
);
  import y2r_pkg::*;

  // storage format: byte, or word shifted down by depth above eight
  function automatic logic [SAMPLE_W-1:0] fetch(input logic [SAMPLE_W-1:0] raw,
                                                input cfg_t c);
    logic [DEPTH_W-1:0] sh;
    sh = '0;
    if (!c.two_byte_samples) begin
      return {{(SAMPLE_W-BYTE_DEPTH){1'b0}}, raw[BYTE_DEPTH-1:0]};
    end
    if (c.bit_depth > DEPTH_W'(BYTE_DEPTH)) begin
      sh = c.bit_depth - DEPTH_W'(BYTE_DEPTH);
    end
    return raw >> sh;
  endfunction

  // negative gives zero, else floor and saturate
  function automatic logic [CHAN_W-1:0] to_channel(input logic signed [SUM_W-1:0] acc);
    if (acc[SUM_W-1]) begin
      return '0;
    end
    if (acc[SUM_W-2:FRAC_BITS+CHAN_W] != '0) begin
      return CHAN_W'(CHAN_MAX);
    end
    return acc[FRAC_BITS+CHAN_W-1:FRAC_BITS];
  endfunction

  logic [3:0] vld;
  logic [3:0] adv;

  logic signed [DIFF_W-1:0] s1_y, s1_u, s1_v;
  logic signed [PROD_W-1:0] s2_py, s2_crv, s2_cgu, s2_cgv, s2_cbu;
  logic signed [SUM_W-1:0]  s3_r, s3_g, s3_b;
  logic [CHAN_W-1:0]        s4_r, s4_g, s4_b;

  logic signed [DIFF_W-1:0] y_off;
  coef_t                    coef;

  // a stage moves when its slot is free or the next one moves
  assign adv[3] = !vld[3] || rgb.ready;
  assign adv[2] = !vld[2] || adv[3];
  assign adv[1] = !vld[1] || adv[2];
  assign adv[0] = !vld[0] || adv[1];
  assign yuv.ready = adv[0];

  assign y_off = cfg.full_range ? '0 : DIFF_W'(LUMA_OFFSET);
  assign coef  = coef_lookup(cfg.full_range, cfg.matrix_select);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= yuv.valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: sample fetch and offset removal
  always_ff @(posedge clk) begin
    if (adv[0] && yuv.valid) begin
      s1_y <= $signed({1'b0, fetch(yuv.luma_sample, cfg)}) - y_off;
      s1_u <= $signed({1'b0, fetch(yuv.blue_diff_sample, cfg)}) - DIFF_W'(CHROMA_OFFSET);
      s1_v <= $signed({1'b0, fetch(yuv.red_diff_sample, cfg)}) - DIFF_W'(CHROMA_OFFSET);
    end
  end

  // stage 2: five products
  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s2_py  <= $signed({1'b0, coef.ys})  * s1_y;
      s2_crv <= $signed({1'b0, coef.crv}) * s1_v;
      s2_cgu <= $signed({1'b0, coef.cgu}) * s1_u;
      s2_cgv <= $signed({1'b0, coef.cgv}) * s1_v;
      s2_cbu <= $signed({1'b0, coef.cbu}) * s1_u;
    end
  end

  // stage 3: channel sums
  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      s3_r <= SUM_W'(s2_py) + SUM_W'(s2_crv);
      s3_g <= SUM_W'(s2_py) - SUM_W'(s2_cgu) - SUM_W'(s2_cgv);
      s3_b <= SUM_W'(s2_py) + SUM_W'(s2_cbu);
    end
  end

  // stage 4: clamp into the output register
  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      s4_r <= to_channel(s3_r);
      s4_g <= to_channel(s3_g);
      s4_b <= to_channel(s3_b);
    end
  end

  assign rgb.valid     = vld[3];
  assign rgb.red_out   = s4_r;
  assign rgb.green_out = s4_g;
  assign rgb.blue_out  = s4_b;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // an accepted transaction with nothing leaving adds one occupied stage
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (yuv.valid && yuv.ready && !(rgb.valid && rgb.ready)) |=>
      $countones(vld) == $past($countones(vld)) + 1)
    else $error("occupancy did not grow on accept");

  // any free slot lets a new transaction in
  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    ($countones(vld) < 4) |-> yuv.ready)
    else $error("input stalled with a free stage");

  // negative red sum clamps to zero
  a_neg_clamp: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && adv[3] && s3_r[SUM_W-1]) |=> rgb.red_out == '0)
    else $error("negative red sum not clamped");

endmodule

// ===== sv/yuv_to_rgb_pixel_converter.sv =====
`timescale 1ns / 1ps

// YCbCr to 8-bit RGB converter for BT.601, BT.709 and BT.2020 matrices.
// Input channel yuv carries one raw Y, Cb, Cr sample triple per transaction;
// output channel rgb carries one clamped R, G, B result per transaction.
// The configuration port (cfg_write, cfg_index, cfg_data) sets matrix,
// range, storage format and bit depth; write it only while no pixel is in
// flight.
// Four register stages: sample fetch, products, sums, clamp. A result passes
// through them in that order and is offered on rgb from the clamp register.
// Throughput is one pixel per clock, sustained while rgb.ready stays high, since every stage is a
// register stage and each multiplier is used once per pixel.
// Reset clears all stage valid bits and restores the configuration defaults
// (BT.709, limited range, byte samples, depth 8).
// When the receiver holds rgb.ready low, the result waits in the output
// register and earlier stages keep filling; yuv.ready drops only once all
// four stages hold a pixel. Nothing is dropped or repeated.
module yuv_to_rgb_pixel_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [y2r_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [y2r_pkg::CFG_DATA_W-1:0] cfg_data,
  y2r_yuv_if.sink                        yuv,
  y2r_rgb_if.source                      rgb
);
  import y2r_pkg::*;

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.matrix_select    <= MAT_BT709;
      cfg.full_range       <= 1'b0;
      cfg.two_byte_samples <= 1'b0;
      cfg.bit_depth        <= DEPTH_W'(BYTE_DEPTH);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MATRIX_SELECT:    cfg.matrix_select    <= matrix_t'(cfg_data[1:0]);
        REG_FULL_RANGE:       cfg.full_range       <= cfg_data[0];
        REG_TWO_BYTE_SAMPLES: cfg.two_byte_samples <= cfg_data[0];
        REG_BIT_DEPTH:        cfg.bit_depth        <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  y2r_pipe u_pipe (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .yuv (yuv),
    .rgb (rgb)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import y2r_pkg::*;

  // one converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // q16 weights of one matrix and range, range scaling folded in
  typedef struct {
    longint luma;
    longint r_cr;
    longint g_cb;
    longint g_cr;
    longint b_cb;
  } q16_coefs_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  y2r_yuv_if yuv ();
  y2r_rgb_if rgb ();

  yuv_to_rgb_pixel_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .yuv       (yuv.sink),
    .rgb       (rgb.source)
  );

  // shadow copy of the converter settings
  matrix_t     cur_matrix;
  logic        cur_full_range;
  logic        cur_word_storage;
  logic [4:0]  cur_depth;

  rgb_t        pending_rgb[$];
  int          error_count;
  logic        idle_on;

  always #5 clk = ~clk;

  // weights for the selected matrix, code 3 behaves as bt.709
  function automatic q16_coefs_t coefs_for(input logic full, input matrix_t m);
    q16_coefs_t k;
    if (!full) begin
      case (m)
        MAT_BT601:  k = '{76309, 104597, 25675, 53279, 132201};
        MAT_BT2020: k = '{76309, 110014, 12277, 42626, 140363};
        default:    k = '{76309, 117489, 13975, 34925, 138438};
      endcase
    end else begin
      case (m)
        MAT_BT601:  k = '{65536, 91881, 22553, 46802, 116130};
        MAT_BT2020: k = '{65536, 96639, 10784, 37444, 123299};
        default:    k = '{65536, 103206, 12276, 30679, 121609};
      endcase
    end
    return k;
  endfunction

  // byte storage keeps the low byte, word storage drops depth - 8 bits when depth is above 8
  function automatic longint unpack_sample(input logic [15:0] raw);
    logic [15:0] s;
    if (!cur_word_storage) return longint'(raw[7:0]);
    s = raw;
    if (cur_depth > 8) s = s >> (cur_depth - 8);
    return longint'(s);
  endfunction

  // negative gives zero, otherwise floor of q16 value saturated at 255
  function automatic logic [7:0] clamp_chan(input longint acc);
    longint q;
    if (acc < 0) return 8'd0;
    q = acc >>> 16;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic rgb_t predict_rgb(input logic [15:0] y_raw, u_raw, v_raw);
    q16_coefs_t k;
    longint     yd;
    longint     ud;
    longint     vd;
    longint     base;
    rgb_t       px;
    k    = coefs_for(cur_full_range, cur_matrix);
    yd   = unpack_sample(y_raw) - (cur_full_range ? 0 : 16);
    ud   = unpack_sample(u_raw) - 128;
    vd   = unpack_sample(v_raw) - 128;
    base = k.luma * yd;
    px.red   = clamp_chan(base + k.r_cr * vd);
    px.green = clamp_chan(base - k.g_cb * ud - k.g_cr * vd);
    px.blue  = clamp_chan(base + k.b_cb * ud);
    return px;
  endfunction

  // raw noise for byte storage and depths above 16, else mostly in-range samples with some raw noise
  function automatic logic [15:0] rand_sample();
    if (!cur_word_storage || cur_depth > 16 || $urandom_range(3) == 0)
      return 16'($urandom);
    if (cur_depth <= 8) return 16'($urandom_range(255));
    return 16'($urandom_range((1 << cur_depth) - 1));
  endfunction

  function automatic void check_chan(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result side: random backpressure and compare against oldest prediction
  always @(posedge clk) begin : rgb_check
    rgb_t want;
    if (rst) begin
      rgb.ready <= 1'b0;
    end else begin
      if (rgb.valid && rgb.ready) begin
        if (pending_rgb.size() == 0) begin
          $display("%0t unexpected rgb transaction: expected none actual %0d %0d %0d",
                   $time, rgb.red_out, rgb.green_out, rgb.blue_out);
          error_count++;
        end else begin
          want = pending_rgb.pop_front();
          check_chan("red", want.red, rgb.red_out);
          check_chan("green", want.green, rgb.green_out);
          check_chan("blue", want.blue, rgb.blue_out);
        end
      end
      rgb.ready <= !idle_on || ($urandom_range(99) >= 33);
    end
  end

  // one yuv transaction, prediction queued at the accepting edge
  task automatic send_pixel(input logic [15:0] y, u, v);
    while (idle_on && $urandom_range(99) < 33) begin
      yuv.valid <= 1'b0;
      @(posedge clk);
    end
    yuv.valid            <= 1'b1;
    yuv.luma_sample      <= y;
    yuv.blue_diff_sample <= u;
    yuv.red_diff_sample  <= v;
    do @(posedge clk); while (!yuv.ready);
    pending_rgb.push_back(predict_rgb(y, u, v));
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  // stop the stream and let the pipeline empty
  task automatic wait_idle();
    yuv.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input matrix_t m, input logic full, input logic word,
                             input logic [4:0] depth);
    wait_idle();
    write_reg(REG_MATRIX_SELECT, CFG_DATA_W'(m));
    write_reg(REG_FULL_RANGE, CFG_DATA_W'(full));
    write_reg(REG_TWO_BYTE_SAMPLES, CFG_DATA_W'(word));
    write_reg(REG_BIT_DEPTH, depth);
    cfg_write        <= 1'b0;
    cur_matrix       = m;
    cur_full_range   = full;
    cur_word_storage = word;
    cur_depth        = depth;
  endtask

  // power-on settings: bt.709, limited range, byte samples
  task automatic test_reset_defaults();
    send_pixel(16'd16, 16'd128, 16'd128);
    send_pixel(16'd235, 16'd128, 16'd128);
    send_pixel(16'hFF00, 16'hFF80, 16'h0080);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF);
    send_pixel(16'd0, 16'd0, 16'd255);
  endtask

  // every matrix code in full range, the unused code included
  task automatic test_matrix_codes();
    for (int m = 0; m < 4; m++) begin
      load_config(matrix_t'(m), 1'b1, 1'b0, 5'd8);
      send_pixel(16'd200, 16'd40, 16'd220);
    end
  endtask

  // word storage: no shift up to depth 8, deep shifts above 16
  task automatic test_word_storage();
    load_config(MAT_BT601, 1'b0, 1'b1, 5'd8);
    send_pixel(16'hFFFF, 16'h0080, 16'h8000);
    send_pixel(16'h0010, 16'h0080, 16'h0080);
    load_config(MAT_BT2020, 1'b1, 1'b1, 5'd16);
    send_pixel(16'hFFFF, 16'h0000, 16'h8000);
    send_pixel(16'h1000, 16'h8000, 16'h8000);
    load_config(MAT_BT709, 1'b0, 1'b1, 5'd31);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_config(MAT_UNSPEC, 1'b0, 1'b1, 5'd0);
    send_pixel(16'h00EB, 16'h0080, 16'h0080);
    load_config(MAT_BT709, 1'b0, 1'b1, 5'd10);
    send_pixel(16'd940, 16'd512, 16'd512);
  endtask

  task automatic test_random_settings();
    int word_depths[4] = '{9, 10, 12, 16};
    int odd_depths[3]  = '{0, 20, 31};
    // byte storage over all matrix codes and both ranges
    for (int m = 0; m < 4; m++) begin
      for (int f = 0; f < 2; f++) begin
        load_config(matrix_t'(m), f[0], 1'b0, 5'($urandom_range(31)));
        send_random(40);
      end
    end
    // word storage at usual depths
    foreach (word_depths[i]) begin
      load_config(matrix_t'($urandom_range(3)), 1'($urandom_range(1)), 1'b1,
                  5'(word_depths[i]));
      send_random(40);
    end
    // word storage at depths outside the usual span
    foreach (odd_depths[i]) begin
      load_config(matrix_t'($urandom_range(3)), 1'($urandom_range(1)), 1'b1,
                  5'(odd_depths[i]));
      send_random(20);
    end
  endtask

  // back-to-back traffic with no stalls on either side
  task automatic test_full_rate();
    load_config(matrix_t'($urandom_range(3)), 1'($urandom_range(1)), 1'b1, 5'd10);
    idle_on = 1'b0;
    send_random(120);
    wait_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = REG_MATRIX_SELECT;
    cfg_data             = '0;
    yuv.valid            = 1'b0;
    yuv.luma_sample      = '0;
    yuv.blue_diff_sample = '0;
    yuv.red_diff_sample  = '0;
    rgb.ready            = 1'b0;
    error_count          = 0;
    idle_on              = 1'b1;
    cur_matrix           = MAT_BT709;
    cur_full_range       = 1'b0;
    cur_word_storage     = 1'b0;
    cur_depth            = 5'd8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_matrix_codes();
    test_word_storage();
    test_random_settings();
    test_full_rate();

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/y2r_pkg.sv
sv/y2r_yuv_if.sv
sv/y2r_rgb_if.sv
sv/y2r_pipe.sv
sv/yuv_to_rgb_pixel_converter.sv
sim/tb_top.sv
